FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define TWM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// property checked at every clock edge, reset included
`define TWM_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

FILE: sv/twm_pkg.sv
// ----------------------------------------------------------------------------
// twm_pkg
// shared types and constants of the weighted tsdf merge core
// ----------------------------------------------------------------------------
package twm_pkg;

    localparam int CFG_WIDTH         = 15;
    localparam int DEF_VALUE_WIDTH   = 16;
    localparam int DEF_WEIGHT_WIDTH  = 16;
    localparam logic [CFG_WIDTH-1:0] WEIGHT_CAP_RST = 15'h7fff;

    // control bits that travel along the pipeline
    typedef struct packed {
        logic valid;
        logic merge;
        logic neg;
        logic last;
    } t_ctrl;

endpackage

FILE: sv/twm_front.sv
// ----------------------------------------------------------------------------
// twm_front
// products, weight sum, case decode, numerator sum and magnitude
// ----------------------------------------------------------------------------
module twm_front
    import twm_pkg::*;
#(
    parameter int VALUE_WIDTH  = DEF_VALUE_WIDTH,
    parameter int WEIGHT_WIDTH = DEF_WEIGHT_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_take,
    input  logic [CFG_WIDTH-1:0]           i_weight_cap,
    input  logic signed [VALUE_WIDTH-1:0]  i_map_value,
    input  logic signed [WEIGHT_WIDTH-1:0] i_map_weight,
    input  logic signed [VALUE_WIDTH-1:0]  i_new_value,
    input  logic signed [WEIGHT_WIDTH-1:0] i_meas_weight,
    input  logic                           i_last_entry,
    output t_ctrl                          o_ctrl,
    output logic [WEIGHT_WIDTH-1:0]        o_rem,
    output logic [VALUE_WIDTH-1:0]         o_shf,
    output logic [WEIGHT_WIDTH-1:0]        o_div,
    output logic [VALUE_WIDTH-1:0]         o_alt,
    output logic [WEIGHT_WIDTH-1:0]        o_wgt
);

    localparam int PW    = VALUE_WIDTH + WEIGHT_WIDTH;
    localparam int CMP_W = (WEIGHT_WIDTH > CFG_WIDTH) ? WEIGHT_WIDTH : CFG_WIDTH;

    // stage 1 next values
    logic                    n_map_pos;
    logic                    n_new_pos;
    logic                    n_merge;
    logic                    n_replace;
    logic [WEIGHT_WIDTH-1:0] n_total;
    logic [CMP_W-1:0]        n_total_x;
    logic [CMP_W-1:0]        n_cap_x;
    logic [CMP_W-1:0]        n_sat_x;
    logic [WEIGHT_WIDTH-1:0] n_wgt;
    logic [VALUE_WIDTH-1:0]  n_alt;

    t_ctrl                   r1_ctrl;
    logic signed [PW-1:0]    r1_p_map;
    logic signed [PW-1:0]    r1_p_new;
    logic [WEIGHT_WIDTH-1:0] r1_div;
    logic [VALUE_WIDTH-1:0]  r1_alt;
    logic [WEIGHT_WIDTH-1:0] r1_wgt;

    logic [PW:0]             n_num;
    t_ctrl                   r2_ctrl;
    logic [PW:0]             r2_num;
    logic [WEIGHT_WIDTH-1:0] r2_div;
    logic [VALUE_WIDTH-1:0]  r2_alt;
    logic [WEIGHT_WIDTH-1:0] r2_wgt;

    logic [PW:0]             n_neg_num;
    logic [PW-1:0]           n_mag;
    t_ctrl                   r3_ctrl;
    logic [PW-1:0]           r3_mag;
    logic [WEIGHT_WIDTH-1:0] r3_div;
    logic [VALUE_WIDTH-1:0]  r3_alt;
    logic [WEIGHT_WIDTH-1:0] r3_wgt;

    // case decode and saturated weight sum
    always_comb begin
        n_map_pos = !i_map_weight[WEIGHT_WIDTH-1] && (i_map_weight != '0);
        n_new_pos = !i_meas_weight[WEIGHT_WIDTH-1] && (i_meas_weight != '0);
        n_merge   = n_map_pos && n_new_pos;
        n_replace = (i_meas_weight != '0) && !n_map_pos;
        // both positive: the sum fits the unsigned weight width
        n_total   = i_map_weight + i_meas_weight;
        n_total_x = CMP_W'(n_total);
        n_cap_x   = CMP_W'(i_weight_cap);
        n_sat_x   = (n_total_x > n_cap_x) ? n_cap_x : n_total_x;
        if (n_merge) begin
            n_wgt = WEIGHT_WIDTH'(n_sat_x);
        end else if (n_replace) begin
            n_wgt = i_meas_weight;
        end else begin
            n_wgt = i_map_weight;
        end
        n_alt = n_replace ? i_new_value : i_map_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctrl <= '0;
        end else begin
            r1_ctrl <= {i_take, n_merge, 1'b0, i_last_entry};
        end
        r1_p_map <= i_map_value * i_map_weight;
        r1_p_new <= i_new_value * i_meas_weight;
        r1_div   <= n_total;
        r1_alt   <= n_alt;
        r1_wgt   <= n_wgt;
    end

    // numerator sum, full width
    assign n_num = {r1_p_map[PW-1], r1_p_map} + {r1_p_new[PW-1], r1_p_new};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctrl <= '0;
        end else begin
            r2_ctrl <= r1_ctrl;
        end
        r2_num <= n_num;
        r2_div <= r1_div;
        r2_alt <= r1_alt;
        r2_wgt <= r1_wgt;
    end

    // magnitude of the numerator, sign kept for the quotient
    assign n_neg_num = (~r2_num) + (PW+1)'(1);
    assign n_mag     = r2_num[PW] ? n_neg_num[PW-1:0] : r2_num[PW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctrl <= '0;
        end else begin
            r3_ctrl <= {r2_ctrl.valid, r2_ctrl.merge, r2_num[PW], r2_ctrl.last};
        end
        r3_mag <= n_mag;
        r3_div <= r2_div;
        r3_alt <= r2_alt;
        r3_wgt <= r2_wgt;
    end

    assign o_ctrl = r3_ctrl;
    assign o_rem  = r3_mag[PW-1:VALUE_WIDTH];
    assign o_shf  = r3_mag[VALUE_WIDTH-1:0];
    assign o_div  = r3_div;
    assign o_alt  = r3_alt;
    assign o_wgt  = r3_wgt;

endmodule

FILE: sv/twm_div_cell.sv
// ----------------------------------------------------------------------------
// twm_div_cell
// one restoring division step: one quotient bit per cell
// ----------------------------------------------------------------------------
module twm_div_cell
    import twm_pkg::*;
#(
    parameter int VALUE_WIDTH  = DEF_VALUE_WIDTH,
    parameter int WEIGHT_WIDTH = DEF_WEIGHT_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctrl                   i_ctrl,
    input  logic [WEIGHT_WIDTH-1:0] i_rem,
    input  logic [VALUE_WIDTH-1:0]  i_shf,
    input  logic [WEIGHT_WIDTH-1:0] i_div,
    input  logic [VALUE_WIDTH-1:0]  i_alt,
    input  logic [WEIGHT_WIDTH-1:0] i_wgt,
    output t_ctrl                   o_ctrl,
    output logic [WEIGHT_WIDTH-1:0] o_rem,
    output logic [VALUE_WIDTH-1:0]  o_shf,
    output logic [WEIGHT_WIDTH-1:0] o_div,
    output logic [VALUE_WIDTH-1:0]  o_alt,
    output logic [WEIGHT_WIDTH-1:0] o_wgt
);

    logic [WEIGHT_WIDTH:0]   n_cand;
    logic [WEIGHT_WIDTH:0]   n_diff;
    logic                    n_ge;
    logic [WEIGHT_WIDTH-1:0] n_rem;

    t_ctrl                   r_ctrl;
    logic [WEIGHT_WIDTH-1:0] r_rem;
    logic [VALUE_WIDTH-1:0]  r_shf;
    logic [WEIGHT_WIDTH-1:0] r_div;
    logic [VALUE_WIDTH-1:0]  r_alt;
    logic [WEIGHT_WIDTH-1:0] r_wgt;

    // remainder stays below the divisor, so it fits the weight width
    always_comb begin
        n_cand = {i_rem, i_shf[VALUE_WIDTH-1]};
        n_diff = n_cand - {1'b0, i_div};
        n_ge   = (n_cand >= {1'b0, i_div});
        n_rem  = n_ge ? n_diff[WEIGHT_WIDTH-1:0] : n_cand[WEIGHT_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else begin
            r_ctrl <= i_ctrl;
        end
        r_rem <= n_rem;
        r_shf <= {i_shf[VALUE_WIDTH-2:0], n_ge};
        r_div <= i_div;
        r_alt <= i_alt;
        r_wgt <= i_wgt;
    end

    assign o_ctrl = r_ctrl;
    assign o_rem  = r_rem;
    assign o_shf  = r_shf;
    assign o_div  = r_div;
    assign o_alt  = r_alt;
    assign o_wgt  = r_wgt;

endmodule

FILE: sv/tsdf_weighted_merge_core.sv
// ----------------------------------------------------------------------------
// tsdf_weighted_merge_core
// weighted-average fusion of a stored tsdf voxel entry with a new measurement
// ----------------------------------------------------------------------------
// One voxel transaction is taken in every clock cycle: busy is always low and
// start may be held high for a whole stream. Each transaction gives exactly one
// result, shown for one cycle with o_valid high. The receiver cannot stall the
// core and must take every result in the cycle it is shown. The divider is a
// row of VALUE_WIDTH cells, each making one quotient bit of the weighted average
// and handing its remainder to the next, behind three front stages (products,
// numerator sum, magnitude) and one output register.
// The weight cap is written through i_cfg_we / i_cfg_wdata, takes effect on the
// next accepted transaction and should only be changed with the pipe empty.
// ----------------------------------------------------------------------------
module tsdf_weighted_merge_core
    import twm_pkg::*;
#(
    parameter int VALUE_WIDTH  = DEF_VALUE_WIDTH,
    parameter int WEIGHT_WIDTH = DEF_WEIGHT_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [CFG_WIDTH-1:0]           i_cfg_wdata,
    // voxel transaction in
    input  logic                           start,
    output logic                           busy,
    input  logic signed [VALUE_WIDTH-1:0]  i_map_value,
    input  logic signed [WEIGHT_WIDTH-1:0] i_map_weight,
    input  logic signed [VALUE_WIDTH-1:0]  i_new_value,
    input  logic signed [WEIGHT_WIDTH-1:0] i_meas_weight,
    input  logic                           i_last_entry,
    // merged result out
    output logic                           o_valid,
    output logic signed [VALUE_WIDTH-1:0]  o_merged_value,
    output logic signed [WEIGHT_WIDTH-1:0] o_merged_weight,
    output logic                           o_last_out
);

    // saturation limit register
    logic [CFG_WIDTH-1:0] r_weight_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight_cap <= WEIGHT_CAP_RST;
        end else if (i_cfg_we) begin
            r_weight_cap <= i_cfg_wdata;
        end
    end

    // fully pipelined, never holds the source off
    assign busy = 1'b0;

    // cell chain taps: index 0 is the front end, index VALUE_WIDTH the last cell
    t_ctrl                   c_ctrl [0:VALUE_WIDTH];
    logic [WEIGHT_WIDTH-1:0] c_rem  [0:VALUE_WIDTH];
    logic [VALUE_WIDTH-1:0]  c_shf  [0:VALUE_WIDTH];
    logic [WEIGHT_WIDTH-1:0] c_div  [0:VALUE_WIDTH];
    logic [VALUE_WIDTH-1:0]  c_alt  [0:VALUE_WIDTH];
    logic [WEIGHT_WIDTH-1:0] c_wgt  [0:VALUE_WIDTH];

    twm_front #(
        .VALUE_WIDTH  (VALUE_WIDTH),
        .WEIGHT_WIDTH (WEIGHT_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (start && !busy),
        .i_weight_cap  (r_weight_cap),
        .i_map_value   (i_map_value),
        .i_map_weight  (i_map_weight),
        .i_new_value   (i_new_value),
        .i_meas_weight (i_meas_weight),
        .i_last_entry  (i_last_entry),
        .o_ctrl        (c_ctrl[0]),
        .o_rem         (c_rem[0]),
        .o_shf         (c_shf[0]),
        .o_div         (c_div[0]),
        .o_alt         (c_alt[0]),
        .o_wgt         (c_wgt[0])
    );

    // quotient bits come out msb first; after the last cell the shift
    // register holds the magnitude of the truncated average
    for (genvar g = 0; g < VALUE_WIDTH; g++) begin : g_cell
        twm_div_cell #(
            .VALUE_WIDTH  (VALUE_WIDTH),
            .WEIGHT_WIDTH (WEIGHT_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (c_ctrl[g]),
            .i_rem   (c_rem[g]),
            .i_shf   (c_shf[g]),
            .i_div   (c_div[g]),
            .i_alt   (c_alt[g]),
            .i_wgt   (c_wgt[g]),
            .o_ctrl  (c_ctrl[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_shf   (c_shf[g+1]),
            .o_div   (c_div[g+1]),
            .o_alt   (c_alt[g+1]),
            .o_wgt   (c_wgt[g+1])
        );
    end

    // sign fix-up and case select
    t_ctrl                  w_end;
    logic [VALUE_WIDTH-1:0] n_quot;
    logic [VALUE_WIDTH-1:0] n_value;

    assign w_end = c_ctrl[VALUE_WIDTH];

    always_comb begin
        // truncation toward zero: negate the magnitude quotient
        n_quot  = w_end.neg ? (~c_shf[VALUE_WIDTH] + VALUE_WIDTH'(1))
                            : c_shf[VALUE_WIDTH];
        n_value = w_end.merge ? n_quot : c_alt[VALUE_WIDTH];
    end

    logic                    r_valid;
    logic [VALUE_WIDTH-1:0]  r_value;
    logic [WEIGHT_WIDTH-1:0] r_weight;
    logic                    r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_end.valid;
        end
        r_value  <= n_value;
        r_weight <= c_wgt[VALUE_WIDTH];
        r_last   <= w_end.last;
    end

    assign o_valid         = r_valid;
    assign o_merged_value  = r_value;
    assign o_merged_weight = r_weight;
    assign o_last_out      = r_last;

endmodule

FILE: sv/twm_checker.sv
// ----------------------------------------------------------------------------
// twm_checker
// port-level checks of the merge core, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module twm_checker
    import twm_pkg::*;
#(
    parameter int VALUE_WIDTH  = DEF_VALUE_WIDTH,
    parameter int WEIGHT_WIDTH = DEF_WEIGHT_WIDTH
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_last_entry,
    input logic o_valid,
    input logic o_last_out
);

    localparam int LAT = VALUE_WIDTH + 4;

    logic w_last_res;

    assign w_last_res = o_valid && o_last_out;

    // core never holds the source off
    `TWM_ASSERT_ALL(a_never_busy, i_clk, !busy, "busy raised")

    // every result traces back to an earlier start
    `TWM_ASSERT(a_result_origin, i_clk, i_rst_n, o_valid |-> $past(start, LAT), "orphan result")

    // last flag follows its own transaction
    `TWM_ASSERT(a_last_ok, i_clk, i_rst_n, w_last_res |-> $past(i_last_entry, LAT), "last lost")

    // reset empties the pipe
    `TWM_ASSERT_ALL(a_reset_clears, i_clk, !i_rst_n |=> !o_valid, "result after reset")

endmodule

bind tsdf_weighted_merge_core twm_checker #(
    .VALUE_WIDTH  (VALUE_WIDTH),
    .WEIGHT_WIDTH (WEIGHT_WIDTH)
) u_twm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_last_entry (i_last_entry),
    .o_valid      (o_valid),
    .o_last_out   (o_last_out)
);
